[rtl/kruskal_union_find_edge_filter_assert.svh]
// Assertion macros shared by the union-find edge filter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_ASSERT_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_ASSERT_SVH

// Same-cycle implication.
`define KUF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KUF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/kuf_pkg.sv]
// Shared types and constants for the union-find edge filter.
// No dependencies; used by the sequencer and the top level.
package kuf_pkg;

   localparam int RANK_BITS = 4;
   localparam logic [RANK_BITS-1:0] RANK_MAX = 4'hF;
   localparam logic [9:0] COUNT_MAX = 10'd1023;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 11;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPORT_MAX = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'b1;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  first_vertex;
      logic [9:0]  second_vertex;
      logic [15:0] edge_weight;
      logic        last_edge;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        vertex_error;
      logic [31:0] tree_result;
      logic [9:0]  edges_taken;
      logic        final_result;
   } rsp_type;

   // Top level to sequencer.
   typedef struct packed {
      logic start;
      logic clear;
      logic skip;
   } kuf_cmd_type;

   // Sequencer to top level.
   typedef struct packed {
      logic idle;
      logic done;
      logic joined;
   } kuf_stat_type;

endpackage

[rtl/kuf_mem.sv]
// Union-find store: one write port, one read port, registered read data.
// Standalone; instantiated by the top level, driven by kuf_seq.
module kuf_mem #(
   parameter int DEPTH = 1024,
   parameter int WORD_BITS = 14
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]     rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/kuf_seq.sv]
// Find/compress/link sequencer around one shared index comparator.
// Uses kuf_pkg and the assertion header; drives the kuf_mem ports.
`include "kruskal_union_find_edge_filter_assert.svh"

module kuf_seq #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  kuf_pkg::kuf_cmd_type                             cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]                  first_vertex,
   input  logic [$clog2(MAX_VERTICES)-1:0]                  second_vertex,
   input  logic                                             rsp_free,
   output kuf_pkg::kuf_stat_type                            stat,
   output logic                                             wr_en,
   output logic [$clog2(MAX_VERTICES)-1:0]                  wr_addr,
   output logic [kuf_pkg::RANK_BITS+$clog2(MAX_VERTICES)-1:0] wr_data,
   output logic [$clog2(MAX_VERTICES)-1:0]                  rd_addr,
   input  logic [kuf_pkg::RANK_BITS+$clog2(MAX_VERTICES)-1:0] rd_data
);

   localparam int VB = $clog2(MAX_VERTICES);
   localparam int RB = kuf_pkg::RANK_BITS;
   localparam logic [VB-1:0] LastIndex = VB'(MAX_VERTICES - 1);

   typedef enum logic [6:0] {
      ST_SWEEP = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FIND  = 7'b0000100,
      ST_COMP  = 7'b0001000,
      ST_LINK  = 7'b0010000,
      ST_LINK2 = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [VB-1:0]   cnt_ff, cnt_in;
   logic            sweep_rsp_ff, sweep_rsp_in;
   logic            joined_ff, joined_in;
   logic            side_ff, side_in;
   logic [VB-1:0]   node_ff, node_in;
   logic [VB-1:0]   start_ff, start_in;
   logic [VB-1:0]   second_ff, second_in;
   logic [VB-1:0]   root_ff, root_in;
   logic [VB-1:0]   ru_ff, ru_in;
   logic [VB-1:0]   rv_ff, rv_in;
   logic [RB-1:0]   rank_u_ff, rank_u_in;
   logic [RB-1:0]   rank_v_ff, rank_v_in;

   logic [VB-1:0]   d_parent;
   logic [RB-1:0]   d_rank;
   logic [VB-1:0]   cmp_a, cmp_b;
   logic            cmp_eq;
   logic [RB-1:0]   rank_v_inc;

   assign d_parent = rd_data[VB-1:0];
   assign d_rank = rd_data[RB+VB-1:VB];
   assign rank_v_inc = (rank_v_ff == kuf_pkg::RANK_MAX) ? rank_v_ff : rank_v_ff + RB'(1);

   // Shared comparator: root test in walk, end of compression, distinct roots.
   always_comb begin
      cmp_a = node_ff;
      cmp_b = d_parent;
      case (state_ff)
         ST_COMP: begin
            cmp_a = node_ff;
            cmp_b = root_ff;
         end
         ST_LINK: begin
            cmp_a = ru_ff;
            cmp_b = rv_ff;
         end
         default: begin
            cmp_a = node_ff;
            cmp_b = d_parent;
         end
      endcase
   end

   assign cmp_eq = (cmp_a == cmp_b);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sweep_rsp_in = sweep_rsp_ff;
      joined_in = joined_ff;
      side_in = side_ff;
      node_in = node_ff;
      start_in = start_ff;
      second_in = second_ff;
      root_in = root_ff;
      ru_in = ru_ff;
      rv_in = rv_ff;
      rank_u_in = rank_u_ff;
      rank_v_in = rank_v_ff;
      wr_en = 1'b0;
      wr_addr = node_ff;
      wr_data = {d_rank, root_ff};
      rd_addr = node_ff;
      stat = '0;
      stat.idle = (state_ff == ST_IDLE);
      case (state_ff)
         ST_SWEEP: begin
            wr_en = 1'b1;
            wr_addr = cnt_ff;
            wr_data = {{RB{1'b0}}, cnt_ff};
            if (cnt_ff == LastIndex) begin
               cnt_in = '0;
               state_in = sweep_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + VB'(1);
            end
         end
         ST_IDLE: begin
            rd_addr = first_vertex;
            if (cmd.start) begin
               joined_in = 1'b0;
               if (cmd.clear) begin
                  sweep_rsp_in = 1'b1;
                  cnt_in = '0;
                  state_in = ST_SWEEP;
               end else if (cmd.skip) begin
                  state_in = ST_DONE;
               end else begin
                  node_in = first_vertex;
                  start_in = first_vertex;
                  second_in = second_vertex;
                  side_in = 1'b0;
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (cmp_eq) begin
               // Root reached: note it, then restart from the vertex to compress.
               root_in = node_ff;
               if (side_ff) begin
                  rv_in = node_ff;
                  rank_v_in = d_rank;
               end else begin
                  ru_in = node_ff;
                  rank_u_in = d_rank;
               end
               rd_addr = start_ff;
               node_in = start_ff;
               state_in = ST_COMP;
            end else begin
               rd_addr = d_parent;
               node_in = d_parent;
            end
         end
         ST_COMP: begin
            if (cmp_eq) begin
               if (side_ff) begin
                  state_in = ST_LINK;
               end else begin
                  side_in = 1'b1;
                  rd_addr = second_ff;
                  node_in = second_ff;
                  start_in = second_ff;
                  state_in = ST_FIND;
               end
            end else begin
               // Point this node at the root, keep its rank, advance along the old chain.
               wr_en = 1'b1;
               wr_addr = node_ff;
               wr_data = {d_rank, root_ff};
               rd_addr = d_parent;
               node_in = d_parent;
            end
         end
         ST_LINK: begin
            state_in = ST_DONE;
            if (!cmp_eq) begin
               joined_in = 1'b1;
               wr_en = 1'b1;
               if (rank_u_ff > rank_v_ff) begin
                  wr_addr = rv_ff;
                  wr_data = {rank_v_ff, ru_ff};
               end else begin
                  wr_addr = ru_ff;
                  wr_data = {rank_u_ff, rv_ff};
                  if (rank_u_ff == rank_v_ff) begin
                     state_in = ST_LINK2;
                  end
               end
            end
         end
         ST_LINK2: begin
            wr_en = 1'b1;
            wr_addr = rv_ff;
            wr_data = {rank_v_inc, rv_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               stat.done = 1'b1;
               stat.joined = joined_ff;
               sweep_rsp_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         cnt_ff <= '0;
         sweep_rsp_ff <= 1'b0;
         joined_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sweep_rsp_ff <= sweep_rsp_in;
         joined_ff <= joined_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      node_ff <= node_in;
      start_ff <= start_in;
      second_ff <= second_in;
      root_ff <= root_in;
      ru_ff <= ru_in;
      rv_ff <= rv_in;
      rank_u_ff <= rank_u_in;
      rank_v_ff <= rank_v_in;
   end

   `KUF_ASSERT_IMP(a_comp_no_collide, clock, reset, (state_ff == ST_COMP) && wr_en, wr_addr != rd_addr, "compression write collides with chain read")
   `KUF_ASSERT_NXT(a_link_joins, clock, reset, (state_ff == ST_LINK) && !cmp_eq, joined_ff && ((state_ff == ST_DONE) || (state_ff == ST_LINK2)), "distinct roots not joined")

endmodule

[rtl/kruskal_union_find_edge_filter.sv]
// Kruskal edge filter top level: config registers, vertex check, totals, result register.
// Uses kuf_pkg, kuf_seq, kuf_mem and the assertion header.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   kuf_pkg::req_type
//   rsp      out  rsp_valid/rsp_ready   kuf_pkg::rsp_type
//   csr      in   csr_wr_en             csr_index, csr_wr_data
//
// An edge walks the parent chain of its first end to the root and compresses that path,
// then does the same for its second end on the forest so compressed, then links the roots,
// with one more write when the link raises a rank. The walk reads the union-find store
// through its single read port. An edge with an out-of-range vertex skips the walk.
// A clear request sweeps the store, setting every vertex as its own root with rank zero;
// reset runs the same sweep. No request is taken during it. One request is in work
// at a time. A result waits in the output register while the next request is taken; the
// next result holds its request in work until the output register is free.
`include "kruskal_union_find_edge_filter_assert.svh"

module kruskal_union_find_edge_filter #(
   parameter int MAX_VERTICES = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  kuf_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output kuf_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [kuf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [kuf_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);

   localparam int VB = $clog2(MAX_VERTICES);
   localparam int WORD = kuf_pkg::RANK_BITS + VB;

   logic                      report_max_ff;
   logic [10:0]               vertex_count_ff;
   logic                      clear_ff, clear_in;
   logic                      err_ff, err_in;
   logic                      last_ff, last_in;
   logic [WEIGHT_BITS-1:0]    weight_ff, weight_in;
   logic [31:0]               sum_ff, sum_in;
   logic [WEIGHT_BITS-1:0]    largest_ff, largest_in;
   logic [9:0]                count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   kuf_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      vertex_bad;
   logic [31:0]               weight_ext;
   logic [32:0]               sum_wide;
   kuf_pkg::kuf_cmd_type      cmd;
   kuf_pkg::kuf_stat_type     stat;
   logic                      mem_wr_en;
   logic [VB-1:0]             mem_wr_addr;
   logic [WORD-1:0]           mem_wr_data;
   logic [VB-1:0]             mem_rd_addr;
   logic [WORD-1:0]           mem_rd_data;

   assign req_ready = stat.idle;
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Limit is the smaller of vertex_count and the store depth.
   assign vertex_bad = (32'(req_data.first_vertex) >= 32'(vertex_count_ff))
                    || (32'(req_data.second_vertex) >= 32'(vertex_count_ff))
                    || (32'(req_data.first_vertex) >= 32'(MAX_VERTICES))
                    || (32'(req_data.second_vertex) >= 32'(MAX_VERTICES));

   assign weight_ext = 32'(req_data.edge_weight);

   assign cmd = '{
      start: req_fire,
      clear: (req_data.opcode == kuf_pkg::OP_CLEAR),
      skip:  (req_data.opcode == kuf_pkg::OP_EDGE) && vertex_bad
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         report_max_ff <= 1'b0;
         vertex_count_ff <= 11'd1024;
      end else if (csr_wr_en) begin
         case (csr_index)
            kuf_pkg::CSR_REPORT_MAX: begin
               report_max_ff <= csr_wr_data[0];
            end
            kuf_pkg::CSR_VERTEX_COUNT: begin
               vertex_count_ff <= csr_wr_data[10:0];
            end
            default: begin
               report_max_ff <= report_max_ff;
            end
         endcase
      end
   end

   // Capture request fields.
   always_comb begin
      clear_in = clear_ff;
      err_in = err_ff;
      last_in = last_ff;
      weight_in = weight_ff;
      if (req_fire) begin
         clear_in = cmd.clear;
         err_in = cmd.skip;
         last_in = req_data.last_edge;
         weight_in = weight_ext[WEIGHT_BITS-1:0];
      end
   end

   assign sum_wide = {1'b0, sum_ff} + 33'(weight_ff);

   // Totals advance together with the result load.
   always_comb begin
      sum_in = sum_ff;
      largest_in = largest_ff;
      count_in = count_ff;
      if (stat.done) begin
         if (clear_ff) begin
            sum_in = '0;
            largest_in = '0;
            count_in = '0;
         end else if (stat.joined) begin
            sum_in = sum_wide[32] ? '1 : sum_wide[31:0];
            if (weight_ff > largest_ff) begin
               largest_in = weight_ff;
            end
            if (count_ff != kuf_pkg::COUNT_MAX) begin
               count_in = count_ff + 10'd1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.accepted = stat.joined && !clear_ff;
         rsp_data_in.vertex_error = err_ff;
         rsp_data_in.tree_result = report_max_ff ? 32'(largest_in) : sum_in;
         rsp_data_in.edges_taken = count_in;
         rsp_data_in.final_result = last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         largest_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         largest_ff <= largest_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff <= clear_in;
      err_ff <= err_in;
      last_ff <= last_in;
      weight_ff <= weight_in;
      rsp_data_ff <= rsp_data_in;
   end

   kuf_seq #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .first_vertex(VB'(req_data.first_vertex)),
      .second_vertex(VB'(req_data.second_vertex)),
      .rsp_free(!rsp_valid_ff || rsp_ready),
      .stat(stat),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   kuf_mem #(
      .DEPTH(MAX_VERTICES),
      .WORD_BITS(WORD)
   ) u_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   `KUF_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "request taken while one is in work")
   `KUF_ASSERT_NXT(a_clear_zeroes, clock, reset, stat.done && clear_ff, (count_ff == 10'd0) && (sum_ff == 32'd0) && (largest_ff == '0), "clear left totals")

endmodule

[verif/kuf_tree_checker.sv]
`timescale 1ns / 1ps
// Result checker for the Kruskal union-find edge filter: predicts each result with its own
// union-find forest and totals, then compares what the block returns. Depends on kuf_pkg.
module kuf_tree_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  kuf_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  kuf_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [kuf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kuf_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   import kuf_pkg::*;

   localparam int VERTICES = 1024;

   logic [9:0]  uf_parent [VERTICES];
   logic [3:0]  uf_rank [VERTICES];
   logic [31:0] weight_total;
   logic [15:0] heaviest;
   logic [9:0]  edge_count;
   logic        show_max;
   logic [10:0] vertex_limit;
   rsp_type     tree_results_q [$];

   function automatic void clear_forest();
      for (int i = 0; i < VERTICES; i++) begin
         uf_parent[i] = 10'(i);
         uf_rank[i] = '0;
      end
      weight_total = '0;
      heaviest = '0;
      edge_count = '0;
   endfunction

   // Walk to the root, then point every vertex on the path straight at it.
   function automatic logic [9:0] find_root(logic [9:0] v);
      logic [9:0] root;
      logic [9:0] nxt;
      int steps;
      root = v;
      steps = 0;
      while (uf_parent[root] != root && steps < VERTICES) begin
         root = uf_parent[root];
         steps++;
      end
      steps = 0;
      while (v != root && steps < VERTICES) begin
         nxt = uf_parent[v];
         uf_parent[v] = root;
         v = nxt;
         steps++;
      end
      return root;
   endfunction

   function automatic rsp_type filter_edge(req_type r);
      rsp_type    p;
      int         cap;
      logic [9:0] ra;
      logic [9:0] rb;
      logic [32:0] total;
      p = '0;
      cap = (vertex_limit > 11'd1024) ? 1024 : int'(vertex_limit);
      if (r.opcode == OP_CLEAR) begin
         clear_forest();
      end else if (r.first_vertex >= cap || r.second_vertex >= cap) begin
         p.vertex_error = 1'b1;
      end else begin
         ra = find_root(r.first_vertex);
         rb = find_root(r.second_vertex);
         if (ra != rb) begin
            p.accepted = 1'b1;
            total = {1'b0, weight_total} + 33'(r.edge_weight);
            weight_total = total[32] ? 32'hFFFF_FFFF : total[31:0];
            if (r.edge_weight > heaviest) heaviest = r.edge_weight;
            if (edge_count != COUNT_MAX) edge_count++;
            // union by rank; on a tie the first root goes under the second
            if (uf_rank[ra] > uf_rank[rb]) begin
               uf_parent[rb] = ra;
            end else if (uf_rank[ra] < uf_rank[rb]) begin
               uf_parent[ra] = rb;
            end else begin
               uf_parent[ra] = rb;
               if (uf_rank[rb] != RANK_MAX) uf_rank[rb]++;
            end
         end
      end
      p.tree_result = show_max ? {16'h0, heaviest} : weight_total;
      p.edges_taken = edge_count;
      p.final_result = r.last_edge;
      return p;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_forest();
         show_max = 1'b0;
         vertex_limit = 11'd1024;
         tree_results_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REPORT_MAX: show_max = csr_wr_data[0];
               CSR_VERTEX_COUNT: vertex_limit = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            tree_results_q.insert(tree_results_q.size(), filter_edge(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (tree_results_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with no request waiting, actual %0h", $time, rsp_data);
            end else begin
               want = tree_results_q.pop_front();
               compare_field("accepted", 32'(want.accepted), 32'(rsp_data.accepted));
               compare_field("vertex_error", 32'(want.vertex_error),
                             32'(rsp_data.vertex_error));
               compare_field("tree_result", want.tree_result, rsp_data.tree_result);
               compare_field("edges_taken", 32'(want.edges_taken), 32'(rsp_data.edges_taken));
               compare_field("final_result", 32'(want.final_result),
                             32'(rsp_data.final_result));
            end
         end
      end
      pending_count = tree_results_q.size();
   end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Top of the union-find edge filter testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on kuf_pkg, the block and kuf_tree_checker.
module tb;
   import kuf_pkg::*;

   localparam int PHASES = 9;
   localparam int SETTLE_CYCLES = 1100;     // covers the clear sweep over the store
   localparam int LONG_HOLD = 400;
   localparam longint TIMEOUT_NS = 64'd100_000_000;

   localparam int PHASE_SHOW_MAX [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
   localparam int PHASE_VERTICES [PHASES] = '{1024, 8, 1, 0, 2047, 1024, 2, 40, 1000};
   localparam int PHASE_ITEMS [PHASES]    = '{240, 200, 30, 30, 250, 300, 60, 300, 250};
   localparam int PRESSURE_PHASE = 5;
   localparam int PAUSE_PHASE = 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   int   fail_count;
   int   pending_count;
   logic hold_off_req = 1'b0;
   logic hold_done = 1'b0;

   int graph_left = 0;
   int w_run = 0;
   int g_span = 1024;
   int vertex_cap = 1024;
   int burst_left = 1;

   always #5 clock = ~clock;

   kruskal_union_find_edge_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   kuf_tree_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic req_type edge_req(int u, int v, int w, bit last);
      req_type r;
      r.opcode = OP_EDGE;
      r.first_vertex = 10'(u);
      r.second_vertex = 10'(v);
      r.edge_weight = 16'(w);
      r.last_edge = last;
      return r;
   endfunction

   function automatic req_type clear_req(bit last);
      req_type r;
      r = '1;
      r.opcode = OP_CLEAR;
      r.last_edge = last;
      return r;
   endfunction

   // Mostly whole graphs: a clear, then edges of rising weight ending on last_edge.
   task automatic make_req(output req_type r);
      int roll;
      roll = $urandom_range(0, 99);
      r = '0;
      if (roll < 4) begin
         r.opcode = 1'($urandom_range(0, 1));
         r.first_vertex = 10'($urandom_range(0, 1023));
         r.second_vertex = 10'($urandom_range(0, 1023));
         r.edge_weight = 16'($urandom_range(0, 65535));
         r.last_edge = 1'($urandom_range(0, 1));
      end else if (graph_left == 0) begin
         r = clear_req(1'($urandom_range(0, 1)));
         r.first_vertex = 10'($urandom_range(0, 1023));
         r.second_vertex = 10'($urandom_range(0, 1023));
         r.edge_weight = 16'($urandom_range(0, 65535));
         graph_left = $urandom_range(1, 90);
         w_run = ($urandom_range(0, 5) == 0) ? $urandom_range(40000, 65535)
                                            : $urandom_range(0, 2000);
         case ($urandom_range(0, 2))
            0: g_span = vertex_cap;
            1: g_span = (vertex_cap < 32) ? vertex_cap : 32;
            default: g_span = (vertex_cap < 6) ? vertex_cap : 6;
         endcase
      end else begin
         r.opcode = OP_EDGE;
         if (g_span == 0) begin
            r.first_vertex = 10'($urandom_range(0, 1023));
            r.second_vertex = 10'($urandom_range(0, 1023));
         end else if (roll < 12 && vertex_cap < 1024) begin
            r.first_vertex = 10'($urandom_range(vertex_cap, 1023));
            r.second_vertex = 10'($urandom_range(0, g_span - 1));
            if ($urandom_range(0, 1) == 1) begin
               r.second_vertex = r.first_vertex;
               r.first_vertex = 10'($urandom_range(0, g_span - 1));
            end
         end else begin
            r.first_vertex = 10'($urandom_range(0, g_span - 1));
            r.second_vertex = 10'($urandom_range(0, g_span - 1));
         end
         w_run = w_run + $urandom_range(0, 400);
         if (w_run > 65535) w_run = 65535;
         r.edge_weight = 16'(w_run);
         graph_left--;
         r.last_edge = (graph_left == 0);
      end
   endtask

   // Called at a falling edge; returns at a falling edge after the request is taken.
   task automatic send_req(input req_type r);
      int gap;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drain(int settle);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic program_registers(int show_max, int vertices);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_REPORT_MAX;
      csr_wr_data <= CSR_DATA_BITS'(show_max);
      @(negedge clock);
      csr_index <= CSR_VERTEX_COUNT;
      csr_wr_data <= CSR_DATA_BITS'(vertices);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      vertex_cap = (vertices > 1024) ? 1024 : vertices;
      graph_left = 0;
   endtask

   // Result back-pressure: runs of different ready patterns, one long hold when asked.
   initial begin
      int mode;
      int run;
      forever begin
         run = $urandom_range(10, 80);
         mode = $urandom_range(0, 3);
         repeat (run) begin
            @(negedge clock);
            if (hold_off_req && !hold_done) begin
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
               hold_done = 1'b1;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 9) != 0);
                  default: rsp_ready <= ($urandom_range(0, 4) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      req_type r;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_drain(SETTLE_CYCLES);
            program_registers(PHASE_SHOW_MAX[ph], PHASE_VERTICES[ph]);
         end
         if (ph == 0) begin
            send_req(clear_req(1'b1));
            send_req(edge_req(0, 1, 0, 1'b0));
            send_req(edge_req(1, 0, 1, 1'b0));           // same set
            send_req(edge_req(5, 5, 2, 1'b0));           // self loop
            send_req(edge_req(1023, 1022, 3, 1'b0));
            send_req(edge_req(1022, 0, 100, 1'b0));      // equal ranks
            send_req(edge_req(1023, 1, 200, 1'b0));      // same set through compression
            send_req(edge_req(2, 3, 300, 1'b0));
            send_req(edge_req(4, 5, 301, 1'b0));
            send_req(edge_req(3, 5, 302, 1'b0));
            send_req(edge_req(2, 1023, 'h8000, 1'b0));
            send_req(edge_req(682, 341, 'hFFFF, 1'b1));
            send_req(edge_req(1, 300, 1, 1'b0));         // weight out of order
            send_req(clear_req(1'b0));
         end else if (ph == 1) begin
            send_req(clear_req(1'b0));
            send_req(edge_req(8, 0, 10, 1'b0));          // first end at the limit
            send_req(edge_req(0, 1023, 11, 1'b0));
            send_req(edge_req(7, 0, 12, 1'b0));
            send_req(edge_req(0, 8, 13, 1'b0));
            send_req(edge_req(6, 7, 'hFFFF, 1'b1));
         end
         if (ph == PRESSURE_PHASE) hold_off_req <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
            if (ph == PAUSE_PHASE && i == PHASE_ITEMS[ph] / 2) wait_drain(0);
            make_req(r);
            send_req(r);
         end
      end
      wait_drain(SETTLE_CYCLES);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/kuf_pkg.sv
rtl/kuf_mem.sv
rtl/kuf_seq.sv
rtl/kruskal_union_find_edge_filter.sv
verif/kuf_tree_checker.sv
verif/tb.sv
